// ----- rtl/ascii_decimal_to_fixed_top_assert.svh -----
// Assertion macros shared by the parser modules. Each one samples on clk
// and is switched off while rst_n is low.
`ifndef ASCII_DECIMAL_TO_FIXED_TOP_ASSERT_SVH
`define ASCII_DECIMAL_TO_FIXED_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define ADF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adf assertion failed");
`define ADF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adf assertion failed");
`else
`define ADF_ASSERT_IMP(label, ante, cons)
`define ADF_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- rtl/adf_pkg.sv -----
package adf_pkg;

    localparam int MANT_DIGITS = 19;
    localparam int EXP_LIMIT   = 40;
    localparam int FRAC_BITS   = 32;

    localparam int VALUE_W   = 64;
    localparam int COUNT_W   = 8;
    localparam int SHIFT_W   = 8;
    localparam int EXP_W     = 10;
    localparam int CNT_W     = $clog2(EXP_LIMIT + 1);
    localparam int CHUNK_W   = 32;
    localparam int NUM_CHUNKS = 4;
    localparam int WORD_W    = CHUNK_W * NUM_CHUNKS;
    localparam int IDX_W     = $clog2(NUM_CHUNKS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reciprocal of ten for a chunk of CHUNK_W bits with a remainder nibble on top.
    localparam int              RECIP_W     = 36;
    localparam int              RECIP_SHIFT = 39;
    localparam logic [RECIP_W-1:0] RECIP10  = 36'hCCCCCCCCD;

    localparam logic [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;

    function automatic logic [VALUE_W-1:0] pow10(input int n);
        logic [VALUE_W-1:0] p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam logic [VALUE_W-1:0] DIGIT_CAP = pow10(MANT_DIGITS - 1);

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_INT,
        PH_FRAC,
        PH_ESIGN,
        PH_EDIG,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN
    } bk_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0]      mantissa;
        logic signed [EXP_W-1:0] exponent;
        logic                    negative;
        logic [COUNT_W-1:0]      count;
    } job_t;

endpackage

// ----- rtl/ascii_decimal_to_fixed_top.sv -----
// The parser takes one byte per cycle while the queue has room. For each number
// the scaler multiplies by ten once per power of ten upward, or divides by ten
// one chunk at a time for each power downward, through at most 40 powers of ten.
// Reset: rst_n is asynchronous and active low; it empties the queue and result
// register and puts the parser in its leading-blank phase with all counts at zero.
module ascii_decimal_to_fixed_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Text input, one item per byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] start_req
    // Parsed numbers, one item per number.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] value (signed Q32.32), [71:64] chars_used
    output logic        m_tuser    // [0] overflow
);
    import adf_pkg::*;

    // The front parser takes a byte in every cycle in which the queue has room.
    // Digits, the point and the exponent are folded into a decimal
    // mantissa and a power-of-ten exponent as the bytes stream past. The byte
    // that does not fit the grammar is not counted; it closes the number and
    // hands a job to the queue.
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    job_t  push_job;
    job_t  pop_job;

    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] chars_used;

    adf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .ch        (s_tdata),
        .start_req (s_tuser),
        .full      (full),
        .push      (push),
        .job       (push_job)
    );

    // The short queue lets the parser carry on with the next number while the
    // scaler is still working through powers of ten for the previous one.
    adf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    // The scaler places the mantissa above the fraction bits in a 128-bit word,
    // then multiplies it by ten once per cycle, or divides it by ten one 32-bit
    // chunk per cycle, until the exponent is used up. Division truncates, so the
    // result rounds toward zero. Magnitudes beyond the signed range saturate and
    // raise the overflow flag. The result waits in an output register, so the
    // scaler can pick up the next job while that register waits to be taken.
    adf_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop        (pop),
        .job        (pop_job),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .value      (value),
        .chars_used (chars_used),
        .overflow   (m_tuser)
    );

    assign m_tdata = {chars_used, value};

endmodule

// ----- rtl/adf_front.sv -----
module adf_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    ch,
    input  logic          start_req,
    input  logic          full,
    output logic          push,
    output adf_pkg::job_t job
);
    import adf_pkg::*;

    phase_t                    phase_reg, phase_next, ph_b;
    logic [VALUE_W-1:0]        mant_reg, mant_next, mant_b;
    logic signed [SHIFT_W-1:0] shift_reg, shift_next, shift_b;
    logic [7:0]                ev_reg, ev_next, ev_b;
    logic                      eneg_reg, eneg_next, eneg_b;
    logic                      vneg_reg, vneg_next, vneg_b;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next, cnt_b, cnt_inc;

    logic                      accept, end_byte;
    logic                      is_dig, is_blank, is_sign, is_e;
    logic [3:0]                digit;
    logic [VALUE_W-1:0]        mant_x10;
    logic [11:0]               ev_x10;
    logic signed [EXP_W-1:0]   shift_ext, ev_ext;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    assign is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign is_e     = (ch == CH_E_LO) || (ch == CH_E_UP);
    assign digit    = 4'(ch - CH_ZERO);

    // A set start flag clears the parse state before this byte is looked at.
    always_comb
    begin
        if (start_req)
        begin
            ph_b    = PH_BLANK;
            mant_b  = '0;
            shift_b = '0;
            ev_b    = '0;
            eneg_b  = 1'b0;
            vneg_b  = 1'b0;
            cnt_b   = '0;
        end
        else
        begin
            ph_b    = phase_reg;
            mant_b  = mant_reg;
            shift_b = shift_reg;
            ev_b    = ev_reg;
            eneg_b  = eneg_reg;
            vneg_b  = vneg_reg;
            cnt_b   = cnt_reg;
        end
    end

    assign mant_x10 = (mant_b << 3) + (mant_b << 1) + VALUE_W'(digit);
    assign ev_x10   = ({4'b0, ev_b} << 3) + ({4'b0, ev_b} << 1) + 12'(digit);
    assign cnt_inc  = (cnt_b == '1) ? cnt_b : cnt_b + 1'b1;

    always_comb
    begin
        phase_next = ph_b;
        mant_next  = mant_b;
        shift_next = shift_b;
        ev_next    = ev_b;
        eneg_next  = eneg_b;
        vneg_next  = vneg_b;
        cnt_next   = cnt_b;
        end_byte   = 1'b0;
        if (ph_b == PH_IDLE)
        begin
            end_byte = 1'b0;
        end
        else if (is_blank && (ph_b == PH_BLANK))
        begin
            cnt_next = cnt_inc;
        end
        else if (is_sign && (ph_b == PH_BLANK))
        begin
            vneg_next  = (ch == CH_MINUS);
            phase_next = PH_INT;
            cnt_next   = cnt_inc;
        end
        else if (is_dig && (ph_b inside {PH_BLANK, PH_INT}))
        begin
            if (mant_b < DIGIT_CAP)
            begin
                mant_next = mant_x10;
            end
            else if (shift_b != {1'b0, {(SHIFT_W-1){1'b1}}})
            begin
                shift_next = shift_b + SHIFT_W'(1);
            end
            phase_next = PH_INT;
            cnt_next   = cnt_inc;
        end
        else if ((ch == CH_DOT) && (ph_b inside {PH_BLANK, PH_INT}))
        begin
            phase_next = PH_FRAC;
            cnt_next   = cnt_inc;
        end
        else if (is_dig && (ph_b == PH_FRAC))
        begin
            // Fraction digits past the mantissa width are dropped, which truncates.
            if ((mant_b < DIGIT_CAP) && (shift_b != {1'b1, {(SHIFT_W-1){1'b0}}}))
            begin
                mant_next  = mant_x10;
                shift_next = shift_b - SHIFT_W'(1);
            end
            cnt_next = cnt_inc;
        end
        else if (is_e && (ph_b inside {PH_BLANK, PH_INT, PH_FRAC}))
        begin
            phase_next = PH_ESIGN;
            cnt_next   = cnt_inc;
        end
        else if (is_sign && (ph_b == PH_ESIGN))
        begin
            eneg_next  = (ch == CH_MINUS);
            phase_next = PH_EDIG;
            cnt_next   = cnt_inc;
        end
        else if (is_dig && (ph_b inside {PH_ESIGN, PH_EDIG}))
        begin
            ev_next    = (ev_x10 > 12'd255) ? 8'd255 : ev_x10[7:0];
            phase_next = PH_EDIG;
            cnt_next   = cnt_inc;
        end
        else
        begin
            end_byte   = 1'b1;
            phase_next = PH_IDLE;
        end
    end

    assign shift_ext = EXP_W'(shift_b);
    assign ev_ext    = EXP_W'({2'b0, ev_b});

    assign push         = accept && end_byte;
    assign job.mantissa = mant_b;
    assign job.exponent = eneg_b ? (shift_ext - ev_ext) : (shift_ext + ev_ext);
    assign job.negative = vneg_b;
    assign job.count    = cnt_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BLANK;
            mant_reg  <= '0;
            shift_reg <= '0;
            ev_reg    <= '0;
            eneg_reg  <= 1'b0;
            vneg_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            mant_reg  <= mant_next;
            shift_reg <= shift_next;
            ev_reg    <= ev_next;
            eneg_reg  <= eneg_next;
            vneg_reg  <= vneg_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/adf_queue.sv -----
`include "ascii_decimal_to_fixed_top_assert.svh"

module adf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  adf_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output adf_pkg::job_t pop_data,
    output logic          empty
);
    import adf_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    `ADF_ASSERT_IMP(a_no_overrun, push && !pop, !full)

endmodule

// ----- rtl/adf_scale.sv -----
`include "ascii_decimal_to_fixed_top_assert.svh"

module adf_scale
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    output logic                        pop,
    input  adf_pkg::job_t               job,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [adf_pkg::VALUE_W-1:0] value,
    output logic [adf_pkg::COUNT_W-1:0] chars_used,
    output logic                        overflow
);
    import adf_pkg::*;

    localparam logic signed [EXP_W-1:0] EXP_HI = EXP_W'(EXP_LIMIT);
    localparam logic signed [EXP_W-1:0] EXP_LO = -EXP_W'(EXP_LIMIT);

    bk_state_t state_reg, state_next;

    logic [NUM_CHUNKS-1:0][CHUNK_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [3:0]         rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic               force_reg, force_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [COUNT_W-1:0] chars_reg, chars_next;
    logic               ovf_reg, ovf_next;

    logic                     out_free, load_out;
    logic [WORD_W-1:0]        word_x10;
    logic [CHUNK_W+3:0]       div_in;
    logic [CHUNK_W+RECIP_W+3:0] div_prod;
    logic [CHUNK_W-1:0]       div_q;
    logic [3:0]               div_r;
    logic [NUM_CHUNKS-1:0][CHUNK_W-1:0] word_div;
    logic signed [EXP_W-1:0]  e_in, e_neg;
    logic [VALUE_W-1:0]       mag, lim;
    logic                     fin_ovf;

    assign out_free = !out_valid_reg || m_tready;

    // One multiply by ten of the whole word.
    assign word_x10 = (word_reg << 3) + (word_reg << 1);

    // One chunk of a divide by ten, high chunk first, remainder carried down.
    assign div_in   = {rem_reg, word_reg[idx_reg]};
    assign div_prod = div_in * RECIP10;
    assign div_q    = div_prod[RECIP_SHIFT +: CHUNK_W];
    assign div_r    = 4'(div_in - ((CHUNK_W + 4)'(div_q) << 3) - ((CHUNK_W + 4)'(div_q) << 1));

    always_comb
    begin
        word_div          = word_reg;
        word_div[idx_reg] = div_q;
    end

    assign e_in  = job.exponent;
    assign e_neg = -job.exponent;

    assign mag     = word_reg[1:0];
    assign lim     = neg_reg ? Q_MIN : Q_MAX;
    assign fin_ovf = force_reg || (word_reg[NUM_CHUNKS-1:2] != '0) || (mag > lim);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    if ((job.mantissa == '0) || (e_in < EXP_LO) || (e_in > EXP_HI)
                        || (e_in == '0))
                    begin
                        state_next = BK_FIN;
                    end
                    else if (e_in > 0)
                    begin
                        state_next = BK_MUL;
                    end
                    else
                    begin
                        state_next = BK_DIV;
                    end
                end
            end
            BK_MUL:
            begin
                if ((cnt_reg == CNT_W'(1)) || (word_x10[WORD_W-1:VALUE_W] != '0))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_DIV:
            begin
                if ((idx_reg == '0) && ((cnt_reg == CNT_W'(1)) || (word_div == '0)))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        load_out   = 1'b0;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        force_next = force_reg;
        count_next = count_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    word_next  = WORD_W'({job.mantissa, {FRAC_BITS{1'b0}}});
                    neg_next   = job.negative;
                    count_next = job.count;
                    force_next = 1'b0;
                    idx_next   = IDX_W'(NUM_CHUNKS - 1);
                    rem_next   = '0;
                    if ((job.mantissa == '0) || (e_in < EXP_LO))
                    begin
                        word_next = '0;
                    end
                    else if (e_in > EXP_HI)
                    begin
                        force_next = 1'b1;
                    end
                    else if (e_in > 0)
                    begin
                        cnt_next = e_in[CNT_W-1:0];
                    end
                    else
                    begin
                        cnt_next = e_neg[CNT_W-1:0];
                    end
                end
            end
            BK_MUL:
            begin
                word_next = word_x10;
                cnt_next  = cnt_reg - 1'b1;
            end
            BK_DIV:
            begin
                word_next = word_div;
                if (idx_reg == '0)
                begin
                    rem_next = '0;
                    idx_next = IDX_W'(NUM_CHUNKS - 1);
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    rem_next = div_r;
                    idx_next = idx_reg - 1'b1;
                end
            end
            BK_FIN:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        chars_next     = chars_reg;
        ovf_next       = ovf_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            value_next     = fin_ovf ? lim : (neg_reg ? -mag : mag);
            chars_next     = count_reg;
            ovf_next       = fin_ovf;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        force_reg <= force_next;
        count_reg <= count_next;
        value_reg <= value_next;
        chars_reg <= chars_next;
        ovf_reg   <= ovf_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign value      = value_reg;
    assign chars_used = chars_reg;
    assign overflow   = ovf_reg;

    `ADF_ASSERT_IMP(a_loop_count, (state_reg == BK_MUL) || (state_reg == BK_DIV), cnt_reg != '0)
    `ADF_ASSERT_IMP(a_div_rem, state_reg == BK_DIV, rem_reg < 4'd10)
    `ADF_ASSERT_IMP(a_ovf_sat, out_valid_reg && ovf_reg, (value_reg == Q_MAX) || (value_reg == Q_MIN))
    `ADF_ASSERT_NXT(a_pop_starts, pop, state_reg != BK_IDLE)

endmodule

// ----- sim/ascii_decimal_to_fixed_checker.sv -----
`timescale 1ns / 100ps

module ascii_decimal_to_fixed_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] start_req
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [63:0] value, [71:64] chars_used
    input  logic        m_tuser,   // [0] overflow
    output int          fail_count,
    output int          pending
);
    import adf_pkg::*;

    typedef struct {
        logic [63:0] value;
        logic [7:0]  chars_used;
        logic        overflow;
    } parsed_number_t;

    parsed_number_t expected_numbers[$];

    // Shadow copy of the parser state.
    phase_t      parse_phase;
    logic [63:0] mantissa;
    int          decimal_shift;
    int          exponent_value;
    logic        exponent_negative;
    logic        value_negative;
    logic [7:0]  byte_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_parse();
        parse_phase       = PH_BLANK;
        mantissa          = '0;
        decimal_shift     = 0;
        exponent_value    = 0;
        exponent_negative = 1'b0;
        value_negative    = 1'b0;
        byte_count        = '0;
    endtask

    task automatic count_byte();
        if (byte_count != 8'd255)
        begin
            byte_count++;
        end
    endtask

    // Exact scaling of the decimal mantissa into Q32.32, truncating toward zero.
    task automatic scale_to_fixed(output logic [63:0] mag, output logic ovf);
        int           e;
        logic [127:0] w;
        logic [63:0]  lim;
        ovf = 1'b0;
        mag = '0;
        if (mantissa == 0)
        begin
            return;
        end
        e   = decimal_shift + (exponent_negative ? -exponent_value : exponent_value);
        lim = value_negative ? Q_MIN : Q_MAX;
        if (e > EXP_LIMIT)
        begin
            ovf = 1'b1;
            mag = lim;
            return;
        end
        if (e < -EXP_LIMIT)
        begin
            return;
        end
        w = {64'd0, mantissa} << FRAC_BITS;
        if (e > 0)
        begin
            for (int k = 0; k < e; k++)
            begin
                w = w * 128'd10;
                if (w[127:64] != 0)
                begin
                    break;
                end
            end
        end
        else
        begin
            for (int k = 0; k < -e; k++)
            begin
                w = w / 128'd10;
            end
        end
        if (w[127:64] != 0 || w[63:0] > lim)
        begin
            ovf = 1'b1;
            mag = lim;
        end
        else
        begin
            mag = w[63:0];
        end
    endtask

    task automatic take_byte(input logic [7:0] c, input logic restart);
        logic           is_digit;
        logic [63:0]    digit;
        logic [63:0]    mag;
        logic           ovf;
        parsed_number_t num;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        digit    = 64'(c - CH_ZERO);
        if (restart)
        begin
            clear_parse();
        end
        if (parse_phase == PH_IDLE)
        begin
            return;
        end
        if ((c == CH_SPACE || c == CH_TAB) && parse_phase == PH_BLANK)
        begin
            count_byte();
        end
        else if ((c == CH_PLUS || c == CH_MINUS) && parse_phase == PH_BLANK)
        begin
            value_negative = (c == CH_MINUS);
            parse_phase    = PH_INT;
            count_byte();
        end
        else if (is_digit && (parse_phase == PH_BLANK || parse_phase == PH_INT))
        begin
            if (mantissa < DIGIT_CAP)
            begin
                mantissa = mantissa * 64'd10 + digit;
            end
            else if (decimal_shift < 127)
            begin
                decimal_shift++;
            end
            parse_phase = PH_INT;
            count_byte();
        end
        else if (c == CH_DOT && (parse_phase == PH_BLANK || parse_phase == PH_INT))
        begin
            parse_phase = PH_FRAC;
            count_byte();
        end
        else if (is_digit && parse_phase == PH_FRAC)
        begin
            if (mantissa < DIGIT_CAP && decimal_shift > -128)
            begin
                mantissa = mantissa * 64'd10 + digit;
                decimal_shift--;
            end
            count_byte();
        end
        else if ((c == CH_E_LO || c == CH_E_UP) && parse_phase <= PH_FRAC)
        begin
            parse_phase = PH_ESIGN;
            count_byte();
        end
        else if ((c == CH_PLUS || c == CH_MINUS) && parse_phase == PH_ESIGN)
        begin
            exponent_negative = (c == CH_MINUS);
            parse_phase       = PH_EDIG;
            count_byte();
        end
        else if (is_digit && (parse_phase == PH_ESIGN || parse_phase == PH_EDIG))
        begin
            exponent_value = exponent_value * 10 + int'(digit);
            if (exponent_value > 255)
            begin
                exponent_value = 255;
            end
            parse_phase = PH_EDIG;
            count_byte();
        end
        else
        begin
            // The ending byte is not consumed; it releases the number.
            scale_to_fixed(mag, ovf);
            num.value      = value_negative ? -mag : mag;
            num.chars_used = byte_count;
            num.overflow   = ovf;
            expected_numbers = {expected_numbers, num};
            parse_phase = PH_IDLE;
        end
    endtask

    task automatic check_number();
        parsed_number_t want;
        if (expected_numbers.size() == 0)
        begin
            report_mismatch("unexpected number", m_tdata[63:0], 64'd0);
            return;
        end
        want = expected_numbers.pop_front();
        if (m_tdata[63:0] !== want.value)
        begin
            report_mismatch("value", m_tdata[63:0], want.value);
        end
        if (m_tdata[71:64] !== want.chars_used)
        begin
            report_mismatch("chars_used", 64'(m_tdata[71:64]), 64'(want.chars_used));
        end
        if (m_tuser !== want.overflow)
        begin
            report_mismatch("overflow", 64'(m_tuser), 64'(want.overflow));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_numbers.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_number();
            end
            if (s_tvalid && s_tready)
            begin
                take_byte(s_tdata, s_tuser);
            end
            pending = expected_numbers.size();
        end
    end

endmodule

// ----- sim/ascii_decimal_to_fixed_top_tb.sv -----
`timescale 1ns / 100ps

module ascii_decimal_to_fixed_top_tb;
    import adf_pkg::*;

    // Roughly the number of text bytes the random part should deliver.
    localparam int RANDOM_BYTES = 1250;
    // Drain time after the last predicted number, to catch anything unexpected.
    localparam int DRAIN_CYCLES = 200;
    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT  = 3000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] ch
    logic        s_tuser;   // [0] start_req
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [63:0] value, [71:64] chars_used
    logic        m_tuser;   // [0] overflow

    int fail_count;
    int pending_numbers;

    // While calm is set neither side inserts idle cycles.
    bit calm;

    // Scratch buffer holding the bytes of one number before it is sent.
    logic [7:0] text_buf[$];

    ascii_decimal_to_fixed_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The checker watches both channels, predicts each number and compares.
    ascii_decimal_to_fixed_checker number_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending_numbers)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver drops tready with a chance of 11 in a hundred, except during
    // the calm stretch, so that back-pressure hits the block in every phase.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    // Watchdog: the count restarts whenever an item moves on either side.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // Presents one item and holds it until the block accepts it. Random idle
    // cycles are inserted in front of the item, and tvalid is only ever
    // assigned once per clock edge.
    task automatic send_item(input logic [7:0] c, input logic restart);
        while (!calm && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Sends a literal string as one number: the first byte restarts the parser.
    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            send_item(text[i], i == 0);
        end
    endtask

    task automatic send_text_buf();
        for (int i = 0; i < text_buf.size(); i++)
        begin
            send_item(text_buf[i], i == 0);
        end
    endtask

    // Appends one byte to the end of the scratch buffer.
    task automatic add_byte(input logic [7:0] c);
        text_buf = {text_buf, c};
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // A byte that cannot continue any number, so the number always ends on it.
    function automatic logic [7:0] pick_end_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
               c == CH_DOT || c == CH_E_LO || c == CH_E_UP || c == CH_SPACE ||
               c == CH_TAB)
        begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // Builds a well-formed number with random content. Now and then a very long
    // run of blanks saturates the byte count, a long integer part overflows the
    // mantissa, a long run of fraction zeros drives the decimal shift to its
    // floor, and a long exponent saturates the exponent value.
    task automatic build_number();
        int k;
        text_buf.delete();
        if ($urandom_range(49) == 0)
        begin
            k = $urandom_range(300, 250);
        end
        else if ($urandom_range(9) < 3)
        begin
            k = $urandom_range(3, 1);
        end
        else
        begin
            k = 0;
        end
        repeat (k) add_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        case ($urandom_range(2))
            0: add_byte(CH_PLUS);
            1: add_byte(CH_MINUS);
            default: ;
        endcase
        k = ($urandom_range(9) == 0) ? $urandom_range(25, 15) : $urandom_range(11);
        repeat (k) add_byte(random_digit());
        if ($urandom_range(1))
        begin
            add_byte(CH_DOT);
            if ($urandom_range(49) == 0)
            begin
                k = $urandom_range(140, 125);
                repeat (k) add_byte(CH_ZERO);
            end
            k = $urandom_range(12);
            repeat (k) add_byte(random_digit());
        end
        if ($urandom_range(99) < 35)
        begin
            add_byte($urandom_range(1) ? CH_E_LO : CH_E_UP);
            case ($urandom_range(2))
                0: add_byte(CH_PLUS);
                1: add_byte(CH_MINUS);
                default: ;
            endcase
            k = ($urandom_range(19) == 0) ? $urandom_range(5, 4) : $urandom_range(2);
            repeat (k) add_byte(random_digit());
        end
        add_byte(pick_end_byte());
    endtask

    initial
    begin
        int bytes_sent;
        int k;

        calm     = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed numbers: zero, a lone sign, point or exponent mark, negative
        // zero, blanks with tabs, the edges of the Q32.32 range, surplus integer
        // and fraction digits, exponents past the limit either way, a saturated
        // exponent, an ending byte with nothing before it, and bytes sent after
        // the ending byte without a restart, which must be ignored.
        send_string("0;");
        send_string("-;");
        send_string(".;");
        send_string("e;");
        send_string("-0;");
        send_string("+7.5,");
        send_string(" \t-12.25e1 ");
        send_string("2147483647.9999999999;");
        send_string("-2147483648;");
        send_string("2147483648;");
        send_string("9223372036854775807x");
        send_string("12345678901234567890123;");
        send_string("1e-41;");
        send_string("1e41;");
        send_string("-1e999999;");
        send_string("0e99;");
        send_string("5E-3;");
        send_string("1.e+2;");
        send_string("-1e-10;");
        send_string("x");
        send_string("1e5e");
        send_string("--");
        send_string("1.2.3");
        send_string("e-;");
        send_string("12a34");

        // Random part: mostly well-formed numbers, some noise with random
        // restarts, and stray bytes after an ending byte that the parser ignores.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            calm = (bytes_sent >= 500) && (bytes_sent < 800);
            if ($urandom_range(99) < 85)
            begin
                build_number();
                send_text_buf();
                bytes_sent += text_buf.size();
                if ($urandom_range(4) == 0)
                begin
                    repeat ($urandom_range(3, 1)) send_item(8'($urandom_range(255)), 1'b0);
                end
            end
            else
            begin
                k = $urandom_range(8, 1);
                for (int i = 0; i < k; i++)
                begin
                    send_item(8'($urandom_range(255)), (i == 0) || ($urandom_range(9) == 0));
                end
                bytes_sent += k;
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Let the checker record the last item, wait for every predicted number,
        // then give the block time to show anything unexpected.
        @(posedge clk);
        wait (pending_numbers == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_numbers == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
